/* sv/linear_probe_hash_table_macros.svh */
// Assertion macros for the linear probing hash table.
// Taken in by the top level with `include; needs nothing else.
`ifndef LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define LPHT_ASSERT_NOW(label, clk, rst, cond, check) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (check)) \
    else $error("lpht same-cycle check failed");

// Next-cycle implication, disabled during reset
`define LPHT_ASSERT_NEXT(label, clk, rst, cond, check) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (check)) \
    else $error("lpht next-cycle check failed");

`endif

/* sv/lpht_pkg.sv */
// Shared constants and types of the linear probing hash table.
// Used by linear_probe_hash_table and its testbench; depends on nothing.
`default_nettype none

package lpht_pkg;

  localparam int MAX_SLOTS   = 1024;
  localparam int SLOT_AW     = $clog2(MAX_SLOTS);
  localparam int KEY_W       = 64;
  localparam int VALUE_W     = 32;
  localparam int ENTRY_W     = VALUE_W + KEY_W;
  localparam int ACTION_W    = 2;
  localparam int STATUS_W    = 3;
  localparam int COUNT_W     = 11;
  localparam int CFG_W       = 4;
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 48;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd10;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_LOOKUP = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED    = 3'd0,
    ST_UPDATED     = 3'd1,
    ST_FOUND       = 3'd2,
    ST_NOT_FOUND   = 3'd3,
    ST_TABLE_FULL  = 3'd4,
    ST_INVALID_KEY = 3'd5,
    ST_CLEARED     = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_INIT,   // clearing sweep after reset, no result
    S_IDLE,
    S_CLEAR,  // clearing sweep for a clear transaction
    S_READ,   // issue slot read
    S_CMP,    // compare slot against key
    S_RESP    // hand result to output register
  } state_t;

endpackage

`default_nettype wire

/* sv/lpht_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
`default_nettype none

module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* sv/linear_probe_hash_table.sv */
// Top level of the linear probing hash table: sequencer, slot RAM, output register.
// Depends on lpht_pkg, lpht_ram and linear_probe_hash_table_macros.svh.
`default_nettype none
`include "linear_probe_hash_table_macros.svh"

// Open-addressing hash table with linear probing over one 1024 x 96 slot RAM
// (key in the low 64 bits, value above). The home slot is the key's low bits
// masked to 2**table_size_log2 slots, the size clamped to 2 .. MAX_SLOTS;
// each probe is one RAM read followed by one key compare. A zero key or
// reserved action goes to the result without probing. A clear writes every
// slot, one per cycle. After reset the same sweep runs with s_axis_tready
// low; configuration writes are taken meanwhile. One transaction is worked
// at a time; a finished result waits in the output register while the next
// transaction is accepted.
module linear_probe_hash_table (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration: table_size_log2
  input  wire logic                              cfg_we,
  input  wire logic [lpht_pkg::CFG_W-1:0]        cfg_wdata,
  // input stream
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [lpht_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // key[63:0], value[95:64]
  input  wire logic [lpht_pkg::ACTION_W-1:0]     s_axis_tuser,  // action[1:0]
  // result stream
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [lpht_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,  // value_out[31:0],
                                                                // entry_count[42:32], 0[47:43]
  output logic [lpht_pkg::STATUS_W-1:0]          m_axis_tuser   // status[2:0]
);

  localparam int SLOT_AW = lpht_pkg::SLOT_AW;
  localparam int KEY_W   = lpht_pkg::KEY_W;
  localparam int VALUE_W = lpht_pkg::VALUE_W;
  localparam int ENTRY_W = lpht_pkg::ENTRY_W;
  localparam int COUNT_W = lpht_pkg::COUNT_W;
  localparam int CFG_W   = lpht_pkg::CFG_W;
  localparam int PAD_W   = lpht_pkg::OUT_TDATA_W - VALUE_W - COUNT_W;

  // control registers
  lpht_pkg::state_t     state, state_next;
  logic [COUNT_W-1:0]   count, count_next;
  logic [CFG_W-1:0]     table_size_log2;
  logic                 out_valid;

  // payload registers
  logic                 act_insert, act_insert_next;
  logic [KEY_W-1:0]     key_q, key_next;
  logic [VALUE_W-1:0]   val_q, val_next;
  logic [SLOT_AW-1:0]   idx, idx_next;
  logic [SLOT_AW-1:0]   probe_cnt, probe_cnt_next;
  lpht_pkg::status_t    res_status, res_status_next;
  logic [VALUE_W-1:0]   res_value, res_value_next;
  lpht_pkg::status_t    out_status;
  logic [VALUE_W-1:0]   out_value;
  logic [COUNT_W-1:0]   out_count;

  // RAM ports
  logic                 ram_we;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic [ENTRY_W-1:0]   ram_rdata;
  logic [KEY_W-1:0]     slot_key;
  logic [VALUE_W-1:0]   slot_val;

  // effective table size
  logic [CFG_W-1:0]     size_log2;
  logic [SLOT_AW-1:0]   mask;

  logic                 load_out;
  logic                 in_fire;

  lpht_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (lpht_pkg::MAX_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  assign slot_key = ram_rdata[KEY_W-1:0];
  assign slot_val = ram_rdata[ENTRY_W-1:KEY_W];

  // clamp size to [1, SLOT_AW] and build the slot mask
  always_comb begin
    if (table_size_log2 == '0) begin
      size_log2 = CFG_W'(1);
    end else if (int'(table_size_log2) > SLOT_AW) begin
      size_log2 = CFG_W'(SLOT_AW);
    end else begin
      size_log2 = table_size_log2;
    end
    mask = ~({SLOT_AW{1'b1}} << size_log2);
  end

  assign s_axis_tready = (state == lpht_pkg::S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign load_out      = (state == lpht_pkg::S_RESP) && (!out_valid || m_axis_tready);

  // state register and control
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= lpht_pkg::S_INIT;
      count           <= '0;
      table_size_log2 <= lpht_pkg::CFG_RESET;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (cfg_we) begin
        table_size_log2 <= cfg_wdata;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers; sweep address starts at zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else begin
      idx <= idx_next;
    end
    act_insert <= act_insert_next;
    key_q      <= key_next;
    val_q      <= val_next;
    probe_cnt  <= probe_cnt_next;
    res_status <= res_status_next;
    res_value  <= res_value_next;
    if (load_out) begin
      out_status <= res_status;
      out_value  <= res_value;
      out_count  <= count;
    end
  end

  // sequencer: next state, RAM write and result
  always_comb begin
    state_next      = state;
    count_next      = count;
    act_insert_next = act_insert;
    key_next        = key_q;
    val_next        = val_q;
    idx_next        = idx;
    probe_cnt_next  = probe_cnt;
    res_status_next = res_status;
    res_value_next  = res_value;
    ram_we          = 1'b0;
    ram_wdata       = {val_q, key_q};

    unique case (state) inside
      lpht_pkg::S_INIT, lpht_pkg::S_CLEAR: begin
        // empty one slot per cycle
        ram_we    = 1'b1;
        ram_wdata = '0;
        idx_next  = idx + SLOT_AW'(1);
        if (idx == {SLOT_AW{1'b1}}) begin
          if (state == lpht_pkg::S_CLEAR) begin
            count_next      = '0;
            res_status_next = lpht_pkg::ST_CLEARED;
            res_value_next  = '0;
            state_next      = lpht_pkg::S_RESP;
          end else begin
            state_next = lpht_pkg::S_IDLE;
          end
        end
      end

      lpht_pkg::S_IDLE: begin
        if (in_fire) begin
          key_next        = s_axis_tdata[KEY_W-1:0];
          val_next        = s_axis_tdata[KEY_W +: VALUE_W];
          act_insert_next = (s_axis_tuser == lpht_pkg::ACT_INSERT);
          idx_next        = s_axis_tdata[SLOT_AW-1:0] & mask;
          probe_cnt_next  = '0;
          res_value_next  = '0;
          case (s_axis_tuser) inside
            lpht_pkg::ACT_CLEAR: begin
              idx_next   = '0;
              state_next = lpht_pkg::S_CLEAR;
            end
            lpht_pkg::ACT_INSERT, lpht_pkg::ACT_LOOKUP: begin
              if (s_axis_tdata[KEY_W-1:0] == '0) begin
                res_status_next = lpht_pkg::ST_INVALID_KEY;
                state_next      = lpht_pkg::S_RESP;
              end else begin
                state_next = lpht_pkg::S_READ;
              end
            end
            default: begin
              // reserved action
              res_status_next = lpht_pkg::ST_INVALID_KEY;
              state_next      = lpht_pkg::S_RESP;
            end
          endcase
        end
      end

      lpht_pkg::S_READ: begin
        state_next = lpht_pkg::S_CMP;
      end

      lpht_pkg::S_CMP: begin
        if (slot_key == key_q) begin
          // key present
          state_next = lpht_pkg::S_RESP;
          if (act_insert) begin
            ram_we          = 1'b1;
            res_status_next = lpht_pkg::ST_UPDATED;
          end else begin
            res_status_next = lpht_pkg::ST_FOUND;
            res_value_next  = slot_val;
          end
        end else if (slot_key == '0) begin
          // empty slot ends the chain
          state_next = lpht_pkg::S_RESP;
          if (act_insert) begin
            ram_we          = 1'b1;
            count_next      = count + COUNT_W'(1);
            res_status_next = lpht_pkg::ST_INSERTED;
          end else begin
            res_status_next = lpht_pkg::ST_NOT_FOUND;
          end
        end else if (probe_cnt == mask) begin
          // every slot probed
          state_next      = lpht_pkg::S_RESP;
          res_status_next = act_insert ? lpht_pkg::ST_TABLE_FULL : lpht_pkg::ST_NOT_FOUND;
        end else begin
          idx_next       = (idx + SLOT_AW'(1)) & mask;
          probe_cnt_next = probe_cnt + SLOT_AW'(1);
          state_next     = lpht_pkg::S_READ;
        end
      end

      lpht_pkg::S_RESP: begin
        if (load_out) begin
          state_next = lpht_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = lpht_pkg::S_IDLE;
      end
    endcase
  end

  // result port
  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_status;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, out_count, out_value};

  // checks
  `LPHT_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= COUNT_W'(lpht_pkg::MAX_SLOTS))
  `LPHT_ASSERT_NOW(a_probe_bound, clk, rst, state == lpht_pkg::S_CMP, probe_cnt <= mask)
  `LPHT_ASSERT_NOW(a_we_states, clk, rst, ram_we,
    state == lpht_pkg::S_INIT || state == lpht_pkg::S_CLEAR || state == lpht_pkg::S_CMP)
  `LPHT_ASSERT_NEXT(a_clear_count, clk, rst,
    load_out && res_status == lpht_pkg::ST_CLEARED, out_count == '0)

endmodule

`default_nettype wire

/* sim/tb_linear_probe_hash_table.sv */
// Self-checking testbench for linear_probe_hash_table: directed and random
// insert / lookup / clear traffic checked against a mirrored hash table.
// Depends on lpht_pkg and the linear_probe_hash_table RTL.
`timescale 1ns / 1ps

module tb_linear_probe_hash_table;

  localparam int MAX_SLOTS   = lpht_pkg::MAX_SLOTS;
  localparam int SLOT_AW     = lpht_pkg::SLOT_AW;
  localparam int KEY_W       = lpht_pkg::KEY_W;
  localparam int VALUE_W     = lpht_pkg::VALUE_W;
  localparam int ACTION_W    = lpht_pkg::ACTION_W;
  localparam int STATUS_W    = lpht_pkg::STATUS_W;
  localparam int COUNT_W     = lpht_pkg::COUNT_W;
  localparam int CFG_W       = lpht_pkg::CFG_W;
  localparam int IN_TDATA_W  = lpht_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = lpht_pkg::OUT_TDATA_W;

  localparam logic [ACTION_W-1:0] ACT_RESERVED = 2'd3;
  localparam int                  POOL_MAX     = 32;

  // One reply as the block should report it
  typedef struct packed {
    lpht_pkg::status_t    status;
    logic [VALUE_W-1:0]   value_out;
    logic [COUNT_W-1:0]   count;
  } hash_reply_t;

  // Mirror of the slot store; predicts one reply per accepted request
  class table_mirror;
    logic [KEY_W-1:0]   slot_key [MAX_SLOTS];
    logic [VALUE_W-1:0] slot_val [MAX_SLOTS];
    int unsigned        n_used;
    logic [CFG_W-1:0]   size_log2;
    hash_reply_t        awaited_replies [$];
    int                 errors;

    function new();
      foreach (slot_key[i]) begin
        slot_key[i] = '0;
        slot_val[i] = '0;
      end
      n_used    = 0;
      size_log2 = lpht_pkg::CFG_RESET;
      errors    = 0;
    endfunction

    function void set_size(logic [CFG_W-1:0] v);
      size_log2 = v;
    endfunction

    // Slots in use: 2**log2, clamped to 2 .. MAX_SLOTS
    function int unsigned slots();
      int unsigned l;
      l = 32'(size_log2);
      if (l < 1) l = 1;
      if (l > SLOT_AW) l = SLOT_AW;
      return 1 << l;
    endfunction

    function int awaiting();
      return awaited_replies.size();
    endfunction

    // Apply one accepted request to the mirror and queue its reply
    function void note_request(logic [ACTION_W-1:0] act, logic [KEY_W-1:0] key,
                               logic [VALUE_W-1:0] val);
      hash_reply_t r;
      int unsigned size;
      int unsigned idx;
      int unsigned probes;
      bit          hit;
      bit          empty;
      r.value_out = '0;
      if (act == lpht_pkg::ACT_CLEAR) begin
        foreach (slot_key[i]) slot_key[i] = '0;
        n_used   = 0;
        r.status = lpht_pkg::ST_CLEARED;
      end else if (act == ACT_RESERVED || key == '0) begin
        r.status = lpht_pkg::ST_INVALID_KEY;
      end else begin
        size  = slots();
        idx   = key[SLOT_AW-1:0] & (size - 1);
        hit   = 1'b0;
        empty = 1'b0;
        // linear probe with wrap, at most one pass over the table
        for (probes = 0; probes < size && !hit && !empty; probes++) begin
          if (slot_key[idx] == key) hit = 1'b1;
          else if (slot_key[idx] == '0) empty = 1'b1;
          else idx = (idx + 1) & (size - 1);
        end
        if (act == lpht_pkg::ACT_INSERT) begin
          if (hit) begin
            slot_val[idx] = val;
            r.status      = lpht_pkg::ST_UPDATED;
          end else if (empty) begin
            slot_key[idx] = key;
            slot_val[idx] = val;
            n_used++;
            r.status      = lpht_pkg::ST_INSERTED;
          end else begin
            r.status = lpht_pkg::ST_TABLE_FULL;
          end
        end else begin
          if (hit) begin
            r.value_out = slot_val[idx];
            r.status    = lpht_pkg::ST_FOUND;
          end else begin
            r.status = lpht_pkg::ST_NOT_FOUND;
          end
        end
      end
      r.count = n_used[COUNT_W-1:0];
      awaited_replies.push_back(r);
    endfunction

    task report_mismatch(string what);
      $display("%0t ns: %s", $time, what);
      errors++;
    endtask

    // Compare one accepted reply against the oldest expectation
    task check_reply(logic [STATUS_W-1:0] st, logic [VALUE_W-1:0] vo,
                     logic [COUNT_W-1:0] cnt);
      hash_reply_t want;
      if (awaited_replies.size() == 0) begin
        report_mismatch($sformatf("reply with nothing awaited, status %0d", st));
        return;
      end
      want = awaited_replies.pop_front();
      if (st !== want.status)
        report_mismatch($sformatf("status got %0d expected %s", st, want.status.name()));
      if (vo !== want.value_out)
        report_mismatch($sformatf("value_out got 0x%0h expected 0x%0h", vo, want.value_out));
      if (cnt !== want.count)
        report_mismatch($sformatf("entry_count got %0d expected %0d", cnt, want.count));
    endtask
  endclass

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  cfg_we        = 1'b0;
  logic [CFG_W-1:0]      cfg_wdata     = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata  = '0;  // key[63:0], value[95:64]
  logic [ACTION_W-1:0]   s_axis_tuser  = '0;  // action[1:0]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;       // value_out[31:0], entry_count[42:32]
  logic [STATUS_W-1:0]   m_axis_tuser;        // status[2:0]

  table_mirror board = new();

  int gap_pct   = 0;  // chance per cycle that the sender holds off
  int stall_pct = 0;  // chance per cycle that the receiver stalls

  logic [KEY_W-1:0] key_pool [POOL_MAX];
  int               pool_n;

  linear_probe_hash_table uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk = ~clk;

  // Result side: check accepted transactions, random backpressure
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      board.check_reply(m_axis_tuser, m_axis_tdata[VALUE_W-1:0],
                        m_axis_tdata[VALUE_W +: COUNT_W]);
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Present one request and hold it until accepted
  task automatic send_item(logic [ACTION_W-1:0] act, logic [KEY_W-1:0] key,
                           logic [VALUE_W-1:0] val);
    while ($urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {val, key};
    s_axis_tuser  <= act;
    do @(posedge clk); while (!s_axis_tready);
    board.note_request(act, key, val);
  endtask

  // Stop sending and wait until every reply is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (board.awaiting() != 0);
  endtask

  // Table size register write, only with the block idle
  task automatic change_size(logic [CFG_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    board.set_size(v);
  endtask

  // Keys for one phase: about half share low bits so chains build up
  task automatic fill_pool(int n);
    logic [KEY_W-1:0] k;
    pool_n = n;
    for (int i = 0; i < n; i++) begin
      k = {$urandom, $urandom};
      if ($urandom_range(0, 1)) k[SLOT_AW-1:0] = SLOT_AW'($urandom_range(0, 7));
      if (k == '0) k = KEY_W'(1);
      key_pool[i] = k;
    end
  endtask

  // Mostly pool inserts and lookups, some noise, invalid requests and rare clears
  task automatic run_random_phase(logic [CFG_W-1:0] log2_v, int n_items);
    int          r;
    int unsigned size;
    change_size(log2_v);
    size = board.slots();
    fill_pool(size <= 8 ? size + 3 : 28);
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      if (r < 1)
        send_item(lpht_pkg::ACT_CLEAR, {$urandom, $urandom}, $urandom);
      else if (r < 4)
        send_item(ACT_RESERVED, {$urandom, $urandom}, $urandom);
      else if (r < 7)
        send_item($urandom_range(0, 1) ? lpht_pkg::ACT_LOOKUP : lpht_pkg::ACT_INSERT,
                  '0, $urandom);
      else if (r < 50)
        send_item(lpht_pkg::ACT_INSERT, key_pool[$urandom_range(0, pool_n - 1)], $urandom);
      else if (r < 90)
        send_item(lpht_pkg::ACT_LOOKUP, key_pool[$urandom_range(0, pool_n - 1)], $urandom);
      else
        send_item($urandom_range(0, 1) ? lpht_pkg::ACT_LOOKUP : lpht_pkg::ACT_INSERT,
                  {$urandom, $urandom}, $urandom);
      // occasional full pause on the sender side
      if ($urandom_range(0, 99) < 2) drain();
    end
    // usually empty the table before the size changes
    if ($urandom_range(0, 3) != 0) send_item(lpht_pkg::ACT_CLEAR, '0, '0);
  endtask

  // Main stimulus
  initial begin
    logic [CFG_W-1:0] phase_sizes [16];
    phase_sizes = '{4'd10, 4'd1, 4'd3, 4'd2, 4'd15, 4'd0, 4'd4, 4'd10,
                    4'd2, 4'd6, 4'd1, 4'd8, 4'd3, 4'd12, 4'd5, 4'd10};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: reset size, empty table, invalid requests, collision chain
    send_item(lpht_pkg::ACT_LOOKUP, 64'h1, 32'h0);
    send_item(lpht_pkg::ACT_INSERT, 64'h0, 32'h1234_5678);
    send_item(lpht_pkg::ACT_LOOKUP, 64'h0, 32'h0);
    send_item(ACT_RESERVED, 64'h5, 32'h0);
    send_item(lpht_pkg::ACT_INSERT, '1, '1);
    send_item(lpht_pkg::ACT_INSERT, 64'h1, 32'h0);
    send_item(lpht_pkg::ACT_INSERT, 64'h401, 32'hDEAD_BEEF);
    send_item(lpht_pkg::ACT_LOOKUP, 64'h401, 32'h0);
    send_item(lpht_pkg::ACT_INSERT, 64'h401, 32'hA5A5_5A5A);
    send_item(lpht_pkg::ACT_LOOKUP, '1, 32'h0);
    send_item(lpht_pkg::ACT_LOOKUP, 64'h401, 32'h0);
    send_item(lpht_pkg::ACT_CLEAR, 64'h401, 32'h0);
    send_item(lpht_pkg::ACT_LOOKUP, 64'h1, 32'h0);

    // smallest table: fill it, overflow it, probe it all
    change_size(4'd1);
    send_item(lpht_pkg::ACT_INSERT, 64'h2, 32'h2222_2222);
    send_item(lpht_pkg::ACT_INSERT, 64'h3, 32'h3333_3333);
    send_item(lpht_pkg::ACT_INSERT, 64'h4, 32'h4444_4444);
    send_item(lpht_pkg::ACT_LOOKUP, 64'h5, 32'h0);
    send_item(lpht_pkg::ACT_INSERT, 64'h3, 32'h0F0F_0F0F);

    // size below range acts as two slots
    change_size(4'd0);
    send_item(lpht_pkg::ACT_LOOKUP, 64'h2, 32'h0);

    // size above range caps; entries kept but home slots move
    change_size(4'd15);
    send_item(lpht_pkg::ACT_LOOKUP, 64'h2, 32'h0);
    send_item(lpht_pkg::ACT_INSERT, 64'h6, 32'h6666_6666);
    change_size(4'd1);
    send_item(lpht_pkg::ACT_LOOKUP, 64'h3, 32'h0);
    send_item(lpht_pkg::ACT_CLEAR, 64'h0, 32'h0);

    // random phases over sizes and idling patterns
    for (int p = 0; p < 16; p++) begin
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 69; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 69; end
        default: begin gap_pct = 17; stall_pct = 17; end
      endcase
      run_random_phase(phase_sizes[p], 56);
    end

    drain();
    repeat (40) @(posedge clk);
    if (board.errors == 0 && board.awaiting() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
